// File: src/bwrc_pkg.sv
// Shared constants, register indexes and the raster-op bit function for the word combiner.
package bwrc_pkg;

  // Default datapath word width
  localparam int unsigned WordBitsDef = 16;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned CtrlW    = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROP_CODE      = 3'd0,
    CFG_SOURCE_SHIFT  = 3'd1,
    CFG_LEFT_BIT      = 3'd2,
    CFG_RIGHT_BIT     = 3'd3,
    CFG_RIGHT_TO_LEFT = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [CtrlW-1:0] RopCodeRst     = 4'd12;
  localparam logic [CtrlW-1:0] SourceShiftRst = 4'd0;
  localparam logic [CtrlW-1:0] LeftBitRst     = 4'd0;
  localparam logic [CtrlW-1:0] RightBitRst    = 4'd15;
  localparam logic             RightToLeftRst = 1'b0;

  // Pick one bit of the truth table: index is {source, destination}
  function automatic logic rop_bit(logic [CtrlW-1:0] op, logic s, logic d);
    logic [1:0] sel;
    sel = {s, d};
    return op[sel];
  endfunction

endpackage

// File: src/bwrc_align.sv
// First stage: funnel-shift the source pair and build the edge mask.
module bwrc_align
  import bwrc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [WORD_BITS-1:0] src_high_i,
  input  logic [WORD_BITS-1:0] src_low_i,
  input  logic [WORD_BITS-1:0] dst_word_i,
  input  logic                 first_word_i,
  input  logic                 last_word_i,
  input  logic [CtrlW-1:0]     source_shift_i,
  input  logic [CtrlW-1:0]     left_bit_i,
  input  logic [CtrlW-1:0]     right_bit_i,
  input  logic                 right_to_left_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] src_o,
  output logic [WORD_BITS-1:0] dst_o,
  output logic [WORD_BITS-1:0] mask_o
);

  localparam logic [WORD_BITS-1:0] Ones = '1;

  logic [2*WORD_BITS-1:0] pair_shifted;
  logic [WORD_BITS-1:0]   lmask, rmask, first_mask, last_mask;
  logic                   valid_q;
  logic [WORD_BITS-1:0]   src_d, src_q, dst_q, mask_d, mask_q;

  // Align the source: low word of the shifted pair
  assign pair_shifted = {src_high_i, src_low_i} >> source_shift_i;
  assign src_d        = pair_shifted[WORD_BITS-1:0];

  // Edge masks; the right mask keeps bits up to and including right_bit
  assign lmask      = Ones >> left_bit_i;
  assign rmask      = ~((Ones >> 1) >> right_bit_i);
  assign first_mask = right_to_left_i ? rmask : lmask;
  assign last_mask  = right_to_left_i ? lmask : rmask;

  always_comb begin
    mask_d = Ones;
    if (first_word_i) begin
      mask_d = mask_d & first_mask;
    end
    if (last_word_i) begin
      mask_d = mask_d & last_mask;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold payload when no transaction enters
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      src_q  <= src_d;
      dst_q  <= dst_word_i;
      mask_q <= mask_d;
    end
  end

  assign valid_o = valid_q;
  assign src_o   = src_q;
  assign dst_o   = dst_q;
  assign mask_o  = mask_q;

endmodule

// File: src/bwrc_rop.sv
// Second stage: apply the boolean raster op to source and destination.
module bwrc_rop
  import bwrc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [WORD_BITS-1:0] src_i,
  input  logic [WORD_BITS-1:0] dst_i,
  input  logic [WORD_BITS-1:0] mask_i,
  input  logic [CtrlW-1:0]     rop_code_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] rop_o,
  output logic [WORD_BITS-1:0] dst_o,
  output logic [WORD_BITS-1:0] mask_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] rop_d, rop_q, dst_q, mask_q;

  // Look up each bit in the op's truth table
  always_comb begin
    for (int unsigned i = 0; i < WORD_BITS; i++) begin
      rop_d[i] = rop_bit(rop_code_i, src_i[i], dst_i[i]);
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold payload when no transaction advances
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rop_q  <= rop_d;
      dst_q  <= dst_i;
      mask_q <= mask_i;
    end
  end

  assign valid_o = valid_q;
  assign rop_o   = rop_q;
  assign dst_o   = dst_q;
  assign mask_o  = mask_q;

endmodule

// File: src/bwrc_merge.sv
// Third stage: merge the op result into the destination under the edge mask.
module bwrc_merge
  import bwrc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [WORD_BITS-1:0] rop_i,
  input  logic [WORD_BITS-1:0] dst_i,
  input  logic [WORD_BITS-1:0] mask_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] result_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] result_d, result_q;

  // Keep destination bits outside the mask
  assign result_d = (rop_i & mask_i) | (dst_i & ~mask_i);

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: src/bitblt_word_rop_combiner_unit.sv
// Top level of the bit-blit word raster-op combiner: config registers and three-stage pipeline.
// Each accepted transaction strobes a result on result_valid_o after the align, raster-op and merge registers.
// Throughput: one transaction per cycle; busy stays low, as every stage advances each cycle.
// Stages: source funnel shift and edge mask, raster-op lookup, masked merge into destination.
// Reset: asynchronous active low; clears the pipeline valid bits and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bitblt_word_rop_combiner_unit
  import bwrc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] src_high_i,
  input  logic [WORD_BITS-1:0] src_low_i,
  input  logic [WORD_BITS-1:0] dst_word_i,
  input  logic                 first_word_i,
  input  logic                 last_word_i,
  output logic                 result_valid_o,
  output logic [WORD_BITS-1:0] result_word_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  logic [CtrlW-1:0]     rop_code_q, source_shift_q, left_bit_q, right_bit_q;
  logic                 right_to_left_q;
  logic                 in_accept;
  logic                 s1_valid, s2_valid;
  logic [WORD_BITS-1:0] s1_src, s1_dst, s1_mask;
  logic [WORD_BITS-1:0] s2_rop, s2_dst, s2_mask;

  // Never hold off a transaction
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rop_code_q      <= RopCodeRst;
      source_shift_q  <= SourceShiftRst;
      left_bit_q      <= LeftBitRst;
      right_bit_q     <= RightBitRst;
      right_to_left_q <= RightToLeftRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROP_CODE:      rop_code_q      <= cfg_wdata_i[CtrlW-1:0];
        CFG_SOURCE_SHIFT:  source_shift_q  <= cfg_wdata_i[CtrlW-1:0];
        CFG_LEFT_BIT:      left_bit_q      <= cfg_wdata_i[CtrlW-1:0];
        CFG_RIGHT_BIT:     right_bit_q     <= cfg_wdata_i[CtrlW-1:0];
        CFG_RIGHT_TO_LEFT: right_to_left_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  bwrc_align #(
    .WORD_BITS(WORD_BITS)
  ) u_align (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_accept),
    .src_high_i     (src_high_i),
    .src_low_i      (src_low_i),
    .dst_word_i     (dst_word_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .source_shift_i (source_shift_q),
    .left_bit_i     (left_bit_q),
    .right_bit_i    (right_bit_q),
    .right_to_left_i(right_to_left_q),
    .valid_o        (s1_valid),
    .src_o          (s1_src),
    .dst_o          (s1_dst),
    .mask_o         (s1_mask)
  );

  bwrc_rop #(
    .WORD_BITS(WORD_BITS)
  ) u_rop (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .src_i     (s1_src),
    .dst_i     (s1_dst),
    .mask_i    (s1_mask),
    .rop_code_i(rop_code_q),
    .valid_o   (s2_valid),
    .rop_o     (s2_rop),
    .dst_o     (s2_dst),
    .mask_o    (s2_mask)
  );

  bwrc_merge #(
    .WORD_BITS(WORD_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .rop_i   (s2_rop),
    .dst_i   (s2_dst),
    .mask_i  (s2_mask),
    .valid_o (result_valid_o),
    .result_o(result_word_o)
  );

  // A result strobes after the align, raster-op and merge registers for each accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == ($past(in_accept && rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)))
    else $error("result strobe does not match accepted transactions");

  // An empty mask writes back the destination unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && (s2_mask == '0)) |=> (result_word_o == $past(s2_dst)))
    else $error("empty mask altered the destination word");

  // Pipeline valid bits only advance from the stage before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid |-> $past(s1_valid))
    else $error("raster-op stage valid without an aligned transaction");

endmodule

// File: verif/tb_bitblt_word_rop_combiner_unit.sv
// Self-checking testbench for the bit-blit word raster-op combiner, with a predicting scoreboard.
module tb_bitblt_word_rop_combiner_unit;
  import bwrc_pkg::*;

  localparam int unsigned WordW       = 16;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseCount  = 20;
  localparam int unsigned PhaseItems  = 88;
  localparam int unsigned LimitCycles = 400000;

  // One word of a blit row as presented to the combiner
  typedef struct packed {
    logic [WordW-1:0] src_high;
    logic [WordW-1:0] src_low;
    logic [WordW-1:0] dst_word;
    logic             first_word;
    logic             last_word;
  } blit_word_t;

  // Local copy of the combiner registers
  typedef struct packed {
    logic [3:0] rop_code;
    logic [3:0] source_shift;
    logic [3:0] left_bit;
    logic [3:0] right_bit;
    logic       right_to_left;
  } blit_regs_t;

  // Predicts each written-back word and checks strobed results in order
  class rop_word_scoreboard;
    blit_regs_t       regs;
    logic [WordW-1:0] expected_words[$];
    int unsigned      mismatches;

    function new();
      regs.rop_code      = RopCodeRst;
      regs.source_shift  = SourceShiftRst;
      regs.left_bit      = LeftBitRst;
      regs.right_bit     = RightBitRst;
      regs.right_to_left = RightToLeftRst;
      mismatches         = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [3:0] value);
      case (idx)
        CFG_ROP_CODE:      regs.rop_code      = value;
        CFG_SOURCE_SHIFT:  regs.source_shift  = value;
        CFG_LEFT_BIT:      regs.left_bit      = value;
        CFG_RIGHT_BIT:     regs.right_bit     = value;
        CFG_RIGHT_TO_LEFT: regs.right_to_left = value[0];
        default: ;
      endcase
    endfunction

    // Shift the source pair, apply the op, merge under the edge mask
    function logic [WordW-1:0] predict_word(blit_word_t w);
      logic [2*WordW-1:0] pair;
      logic [WordW-1:0]   s, d, r, lmask, rmask, mask;
      pair  = {w.src_high, w.src_low};
      s     = WordW'(pair >> regs.source_shift);
      d     = w.dst_word;
      lmask = {WordW{1'b1}} >> regs.left_bit;
      rmask = {WordW{1'b1}} << (15 - int'(regs.right_bit));
      r = ({WordW{regs.rop_code[0]}} & ~s & ~d) |
          ({WordW{regs.rop_code[1]}} & ~s &  d) |
          ({WordW{regs.rop_code[2]}} &  s & ~d) |
          ({WordW{regs.rop_code[3]}} &  s &  d);
      mask = {WordW{1'b1}};
      if (w.first_word) mask &= regs.right_to_left ? rmask : lmask;
      if (w.last_word)  mask &= regs.right_to_left ? lmask : rmask;
      return (r & mask) | (d & ~mask);
    endfunction

    function void note_input(blit_word_t w);
      expected_words.push_back(predict_word(w));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [WordW-1:0] got);
      logic [WordW-1:0] want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result_word %h", got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want)
          report_mismatch($sformatf("result_word %h, predicted %h", got, want));
      end
    endtask

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [WordW-1:0]    src_high_i;
  logic [WordW-1:0]    src_low_i;
  logic [WordW-1:0]    dst_word_i;
  logic                first_word_i;
  logic                last_word_i;
  logic                result_valid_o;
  logic [WordW-1:0]    result_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rop_word_scoreboard sb;

  bitblt_word_rop_combiner_unit #(.WORD_BITS(WordW)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .src_high_i     (src_high_i),
    .src_low_i      (src_low_i),
    .dst_word_i     (dst_word_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .result_valid_o (result_valid_o),
    .result_word_o  (result_word_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LimitCycles * 10);
    $display("TB_ERROR");
    $finish;
  end

  // Check every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_word_o);
  end

  // Present one word and hold it until a transaction is taken
  task send_word(blit_word_t w);
    start        <= 1'b1;
    src_high_i   <= w.src_high;
    src_low_i    <= w.src_low;
    dst_word_i   <= w.dst_word;
    first_word_i <= w.first_word;
    last_word_i  <= w.last_word;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_input(w);
  endtask

  // Drop start and idle for the given count of cycles
  task idle_gap(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain the pipeline, then load all five registers
  task load_regs(blit_regs_t r);
    cfg_idx_e   idx_list[5];
    logic [3:0] val_list[5];
    idx_list = '{CFG_ROP_CODE, CFG_SOURCE_SHIFT, CFG_LEFT_BIT, CFG_RIGHT_BIT,
                 CFG_RIGHT_TO_LEFT};
    val_list = '{r.rop_code, r.source_shift, r.left_bit, r.right_bit,
                 {3'b000, r.right_to_left}};
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= val_list[i];
      @(posedge clk_i);
      sb.set_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random word, biased now and then towards the extremes
  function logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return WordW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Pick a register value, forcing the extremes in some phases
  function logic [3:0] pick_field(int unsigned ph, int unsigned salt);
    case ((ph + salt) % 4)
      0:       return 4'd0;
      1:       return 4'd15;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    blit_word_t  w;
    blit_regs_t  r;
    int unsigned idle_pct;
    int unsigned sent;
    int unsigned row_len;
    int unsigned idle_plan[3];

    idle_plan = '{0, 46, 9};
    sb = new();

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    src_high_i   <= '0;
    src_low_i    <= '0;
    dst_word_i   <= '0;
    first_word_i <= 1'b0;
    last_word_i  <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_ROP_CODE;
    cfg_wdata_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: plain copy, every flag combination, field extremes
    send_word('{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0});
    send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1});
    send_word('{16'hAAAA, 16'h5555, 16'h0F0F, 1'b1, 1'b0});
    send_word('{16'h5555, 16'hAAAA, 16'hF0F0, 1'b0, 1'b1});
    idle_gap(1);
    send_word('{16'h8001, 16'h7FFE, 16'hFFFF, 1'b0, 1'b0});

    // Right to left, largest shift, XOR, edges that do not overlap
    r = '{4'd6, 4'd15, 4'd12, 4'd3, 1'b1};
    load_regs(r);
    send_word('{16'h1234, 16'hFEDC, 16'hA5A5, 1'b1, 1'b1});
    send_word('{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0});
    send_word('{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1});
    send_word('{16'hC3C3, 16'h3C3C, 16'h0000, 1'b0, 1'b0});

    // Destination-only op leaves every word as read
    r = '{4'd10, 4'd7, 4'd0, 4'd15, 1'b0};
    load_regs(r);
    send_word('{16'hFFFF, 16'hFFFF, 16'h1357, 1'b1, 1'b1});
    send_word('{16'h0000, 16'h0000, 16'hECA8, 1'b0, 1'b0});

    // Constant ops with a single-bit row at each end
    r = '{4'd0, 4'd1, 4'd15, 4'd0, 1'b0};
    load_regs(r);
    send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0});
    send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1});
    r = '{4'd15, 4'd8, 4'd15, 4'd0, 1'b1};
    load_regs(r);
    send_word('{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0});
    send_word('{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1});

    // Random phases: every op in turn, then random settings
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      r.rop_code      = (ph < 16) ? 4'(ph) : 4'($urandom_range(0, 15));
      r.source_shift  = pick_field(ph, 0);
      r.left_bit      = pick_field(ph, 1);
      r.right_bit     = pick_field(ph, 2);
      r.right_to_left = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      load_regs(r);
      idle_pct = idle_plan[ph % 3];
      sent = 0;
      while (sent < PhaseItems) begin
        // Mostly whole rows; now and then loose flags
        row_len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < row_len; k++) begin
          w.src_high = pick_word();
          w.src_low  = pick_word();
          w.dst_word = pick_word();
          if ($urandom_range(0, 4) == 0) begin
            w.first_word = 1'($urandom_range(0, 1));
            w.last_word  = 1'($urandom_range(0, 1));
          end else begin
            w.first_word = (k == 0);
            w.last_word  = (k == row_len - 1);
          end
          send_word(w);
          sent++;
          if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 4));
        end
      end
    end

    // Let the pipeline empty out
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: bitblt_word_rop_combiner_unit.f
src/bwrc_pkg.sv
src/bwrc_align.sv
src/bwrc_rop.sv
src/bwrc_merge.sv
src/bitblt_word_rop_combiner_unit.sv
verif/tb_bitblt_word_rop_combiner_unit.sv
